FILE: design/vpnt_pkg.sv
// Shared types, constants and helpers of the vertex position and normal transform.
`default_nettype none

package vpnt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int N_REGS = 8;
   localparam int DEN_W = 64;
   localparam int QUO_W = 34;
   localparam int ROOT_STAGES = 32;
   localparam int MAG_W = 30;
   localparam int NORM_W = 128;
   localparam int FRONT_STAGES = 12;
   localparam int PIPE_DEPTH = FRONT_STAGES + ROOT_STAGES + 1 + QUO_W + 1;

   typedef enum logic [2:0] {
      REG_R0_C01,
      REG_R0_C23,
      REG_R1_C01,
      REG_R1_C23,
      REG_R2_C01,
      REG_R2_C23,
      REG_R3_C01,
      REG_R3_C23
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_WZERO,
      ST_DEGEN,
      ST_SAT
   } status_type;

   typedef logic [2:0][NORM_W-1:0] nvec_type;

   typedef struct packed {
      logic                      op;
      status_type                code;
      logic [2:0]                neg;
      logic [2:0][DEN_W-1:0]     val;
      logic [DEN_W-1:0]          den;
   } track_type;

   typedef struct packed {
      logic       op;
      status_type code;
      logic [2:0] neg;
      logic [2:0] presat;
   } dside_type;

   // One step of the normalizing shift: all three words move left together
   // when the top bits of their union are clear.
   function automatic nvec_type norm_step(input nvec_type v, input int sh);
      logic [NORM_W-1:0] orw;
      nvec_type          r;
      orw = v[0] | v[1] | v[2];
      r = v;
      if ((orw >> (NORM_W - sh)) == '0) begin
         for (int i = 0; i < 3; i++) begin
            r[i] = v[i] << sh;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/vpnt_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module vpnt_isqrt (
   input  wire logic        clock,
   input  wire logic [63:0] radicand,
   output logic      [31:0] root
);

   localparam int NS = vpnt_pkg::ROOT_STAGES;

   logic [63:0] rad_ff  [NS];
   logic [63:0] root_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam logic [63:0] BITV = 64'(1) << (62 - 2 * k);
      logic [63:0] rad_prev;
      logic [63:0] root_prev;
      logic [63:0] trial;

      if (k == 0) begin : g_first
         assign rad_prev = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign trial = root_prev + BITV;

      always_ff @(posedge clock) begin
         if (rad_prev >= trial) begin
            rad_ff[k] <= rad_prev - trial;
            root_ff[k] <= (root_prev >> 1) + BITV;
         end else begin
            rad_ff[k] <= rad_prev;
            root_ff[k] <= root_prev >> 1;
         end
      end
   end

   assign root = root_ff[NS-1][31:0];

endmodule

`default_nettype wire

FILE: design/vpnt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module vpnt_div (
   input  wire logic                          clock,
   input  wire logic [vpnt_pkg::DEN_W-1:0]    dividend_hi,
   input  wire logic [vpnt_pkg::QUO_W-1:0]    dividend_lo,
   input  wire logic [vpnt_pkg::DEN_W-1:0]    divisor,
   output logic      [vpnt_pkg::QUO_W-1:0]    quotient
);

   localparam int DW = vpnt_pkg::DEN_W;
   localparam int QW = vpnt_pkg::QUO_W;

   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] lo_prev;
      logic [QW-1:0] quo_prev;
      logic [DW:0]   trial;
      logic [DW:0]   diff;

      if (k == 0) begin : g_first
         assign rem_prev = dividend_hi;
         assign den_prev = divisor;
         assign lo_prev = dividend_lo;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign lo_prev = lo_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign trial = {rem_prev, lo_prev[QW-1]};
      assign diff = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         den_ff[k] <= den_prev;
         lo_ff[k] <= lo_prev << 1;
         if (trial >= {1'b0, den_prev}) begin
            rem_ff[k] <= diff[DW-1:0];
            quo_ff[k] <= {quo_prev[QW-2:0], 1'b1};
         end else begin
            rem_ff[k] <= trial[DW-1:0];
            quo_ff[k] <= {quo_prev[QW-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

`default_nettype wire

FILE: design/vertex_position_normal_transform.sv
// Top level of the vertex position and normal transform pipeline.
//
// A transaction is offered on req_op and req_in_x/y/z with start; it is taken
// at a rising edge where start is high and busy is low. busy is high only
// right after reset, so one transaction can be taken on every clock.
// A position (op 0) is multiplied as (x,y,z,1) by the 4x4 matrix and divided
// by w; a normal (op 1) is multiplied by the cofactor matrix of the upper 3x3,
// signed by its determinant and scaled to unit length.
// Each result is shown for one cycle with rsp_valid, in order. Results pass
// through the 32-stage square root and the 34-stage quotient divider that
// follow the multiply stages; cofactors are registered from the matrix.
// One transaction per clock while busy is low; the receiver cannot stall.
// The matrix is written through csr_wr_en, csr_index and csr_wdata, by the
// user only while no transaction is in flight; the block does not enforce it.
// Synchronous reset loads the identity matrix and empties the pipeline.
`default_nettype none

module vertex_position_normal_transform #(
   parameter int FRAC_BITS = vpnt_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic signed [31:0] req_in_x,
   input  wire logic signed [31:0] req_in_y,
   input  wire logic signed [31:0] req_in_z,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_wr_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);

   localparam int DW = vpnt_pkg::DEN_W;
   localparam int QW = vpnt_pkg::QUO_W;
   localparam int NS = vpnt_pkg::ROOT_STAGES;
   localparam int PD = vpnt_pkg::PIPE_DEPTH;
   localparam int MW = vpnt_pkg::MAG_W;
   localparam int NW = vpnt_pkg::NORM_W;
   localparam int ACC_W = 66;
   localparam int COF_W = 65;
   localparam int U_W = 100;
   localparam int NUM_W = DW + FRAC_BITS + 1;
   localparam int PS_W = DW + QW;
   localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

   // Configuration and derived cofactors.
   logic [63:0]              regs_ff [vpnt_pkg::N_REGS];
   logic signed [31:0]       mat [4][4];
   logic signed [63:0]       cpa_ff [3][3];
   logic signed [63:0]       cpb_ff [3][3];
   logic signed [COF_W-1:0]  cof_ff [3][3];
   logic signed [COF_W-1:0]  dph_ff [3];
   logic signed [COF_W-1:0]  dpl_ff [3];
   logic signed [U_W-1:0]    det_in;
   logic                     det_neg_ff;
   logic                     det_zero_ff;

   // Control.
   logic                     busy_ff;
   logic                     accept;
   logic [PD-1:0]            vld_ff;

   // Front stages.
   logic                     op1_ff, op2_ff, op3_ff, op4_ff, op5_ff;
   logic signed [31:0]       vec1_ff [3];
   logic signed [31:0]       vec2_ff [3];
   logic signed [63:0]       pp_ff [4][3];
   logic signed [COF_W-1:0]  nh_ff [3][3];
   logic signed [COF_W-1:0]  nl_ff [3][3];
   logic signed [ACC_W-1:0]  acc_ff [4];
   logic signed [U_W-1:0]    t_ff [3][3];
   logic signed [U_W-1:0]    usum_in [3];
   logic signed [U_W-1:0]    u5_ff [3];
   logic [DW-1:0]            pabs5_ff [3];
   logic [2:0]               pneg5_ff;
   logic [DW-1:0]            den5_ff;
   logic                     wzero5_ff;
   logic                     degen5_ff;
   vpnt_pkg::track_type      trk6_in;
   vpnt_pkg::nvec_type       n6_in;
   vpnt_pkg::track_type      trk6_ff, trk7_ff, trk8_ff, trk9_ff, trk10_ff, trk11_ff, trk12_ff;
   vpnt_pkg::track_type      trk10_in;
   vpnt_pkg::nvec_type       n6_ff, n7_ff, n8_ff, n9_ff;
   logic [2*MW-1:0]          sq_ff [3];
   logic [63:0]              ssum_ff;

   // Root and divider stages.
   vpnt_pkg::track_type      trk_d_ff [NS];
   logic [31:0]              root;
   logic [DW-1:0]            dhi_ff [3];
   logic [QW-1:0]            dlo_ff [3];
   logic [DW-1:0]            dden_ff;
   vpnt_pkg::dside_type      ds_in;
   vpnt_pkg::dside_type      ds_ff;
   vpnt_pkg::dside_type      ds_d_ff [QW];
   logic [QW-1:0]            quo [3];
   logic [DW-1:0]            div_den_in;
   logic [DW-1:0]            dhi_in [3];
   logic [QW-1:0]            dlo_in [3];

   // Output stage.
   logic signed [31:0]       res_in [3];
   vpnt_pkg::status_type     st_in;
   logic signed [31:0]       res_ff [3];
   vpnt_pkg::status_type     st_ff;
   logic                     kind_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if ((c % 2) == 1) begin
               mat[r][c] = regs_ff[3'(r * 2 + c / 2)][63:32];
            end else begin
               mat[r][c] = regs_ff[3'(r * 2 + c / 2)][31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vpnt_pkg::N_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         regs_ff[vpnt_pkg::REG_R0_C01] <= ONE;
         regs_ff[vpnt_pkg::REG_R1_C01] <= ONE << 32;
         regs_ff[vpnt_pkg::REG_R2_C23] <= ONE;
         regs_ff[vpnt_pkg::REG_R3_C23] <= ONE << 32;
      end else if (csr_wr_en) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      int r0, r1, c0, c1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            r0 = (i == 0) ? 1 : 0;
            r1 = (i == 2) ? 1 : 2;
            c0 = (j == 0) ? 1 : 0;
            c1 = (j == 2) ? 1 : 2;
            cpa_ff[i][j] <= mat[r0][c0] * mat[r1][c1];
            cpb_ff[i][j] <= mat[r0][c1] * mat[r1][c0];
            if (((i + j) % 2) == 1) begin
               cof_ff[i][j] <= COF_W'(cpb_ff[i][j]) - COF_W'(cpa_ff[i][j]);
            end else begin
               cof_ff[i][j] <= COF_W'(cpa_ff[i][j]) - COF_W'(cpb_ff[i][j]);
            end
         end
      end
      for (int j = 0; j < 3; j++) begin
         dph_ff[j] <= mat[0][j] * $signed(cof_ff[0][j][COF_W-1:32]);
         dpl_ff[j] <= mat[0][j] * $signed({1'b0, cof_ff[0][j][31:0]});
      end
      det_neg_ff <= det_in[U_W-1];
      det_zero_ff <= (det_in == '0);
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (U_W'(dph_ff[j]) <<< 32) + U_W'(dpl_ff[j]);
      end
   end

   assign accept = start && !busy_ff;
   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff <= {vld_ff[PD-2:0], accept};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         usum_in[i] = t_ff[i][0] + t_ff[i][1] + t_ff[i][2];
         if (det_neg_ff) begin
            usum_in[i] = -usum_in[i];
         end
      end
   end

   always_comb begin
      logic [U_W-1:0] mag;
      logic           allz;
      allz = 1'b1;
      trk6_in.op = op5_ff;
      trk6_in.den = den5_ff;
      for (int i = 0; i < 3; i++) begin
         mag = u5_ff[i][U_W-1] ? U_W'(-u5_ff[i]) : U_W'(u5_ff[i]);
         n6_in[i] = NW'(mag);
         if (u5_ff[i] != '0) begin
            allz = 1'b0;
         end
         trk6_in.val[i] = pabs5_ff[i];
         trk6_in.neg[i] = op5_ff ? u5_ff[i][U_W-1] : pneg5_ff[i];
      end
      if (op5_ff) begin
         trk6_in.code = (degen5_ff || allz) ? vpnt_pkg::ST_DEGEN : vpnt_pkg::ST_OK;
      end else begin
         trk6_in.code = wzero5_ff ? vpnt_pkg::ST_WZERO : vpnt_pkg::ST_OK;
      end
   end

   always_comb begin
      trk10_in = trk9_ff;
      if (trk9_ff.op) begin
         for (int i = 0; i < 3; i++) begin
            trk10_in.val[i] = DW'(n9_ff[i][NW-1 -: MW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [ACC_W-1:0] a;
      op1_ff <= req_op;
      vec1_ff[0] <= req_in_x;
      vec1_ff[1] <= req_in_y;
      vec1_ff[2] <= req_in_z;
      op2_ff <= op1_ff;
      vec2_ff <= vec1_ff;

      op3_ff <= op2_ff;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            pp_ff[r][c] <= mat[r][c] * vec2_ff[c];
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nh_ff[i][j] <= $signed(cof_ff[i][j][COF_W-1:32]) * vec2_ff[j];
            nl_ff[i][j] <= $signed({1'b0, cof_ff[i][j][31:0]}) * vec2_ff[j];
         end
      end

      op4_ff <= op3_ff;
      for (int r = 0; r < 4; r++) begin
         acc_ff[r] <= (ACC_W'(mat[r][3]) <<< FRAC_BITS) + ACC_W'(pp_ff[r][0])
                      + ACC_W'(pp_ff[r][1]) + ACC_W'(pp_ff[r][2]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            t_ff[i][j] <= (U_W'(nh_ff[i][j]) <<< 32) + U_W'(nl_ff[i][j]);
         end
      end

      op5_ff <= op4_ff;
      for (int i = 0; i < 3; i++) begin
         u5_ff[i] <= usum_in[i];
         a = acc_ff[i][ACC_W-1] ? -acc_ff[i] : acc_ff[i];
         pabs5_ff[i] <= a[DW-1:0];
         pneg5_ff[i] <= acc_ff[i][ACC_W-1] ^ acc_ff[3][ACC_W-1];
      end
      a = acc_ff[3][ACC_W-1] ? -acc_ff[3] : acc_ff[3];
      den5_ff <= a[DW-1:0];
      wzero5_ff <= (acc_ff[3] == '0);
      degen5_ff <= det_zero_ff;

      trk6_ff <= trk6_in;
      n6_ff <= n6_in;
      trk7_ff <= trk6_ff;
      n7_ff <= vpnt_pkg::norm_step(vpnt_pkg::norm_step(vpnt_pkg::norm_step(n6_ff, 64), 32), 16);
      trk8_ff <= trk7_ff;
      n8_ff <= vpnt_pkg::norm_step(vpnt_pkg::norm_step(n7_ff, 8), 4);
      trk9_ff <= trk8_ff;
      n9_ff <= vpnt_pkg::norm_step(vpnt_pkg::norm_step(n8_ff, 2), 1);

      trk10_ff <= trk10_in;
      trk11_ff <= trk10_ff;
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= trk10_ff.val[i][MW-1:0] * trk10_ff.val[i][MW-1:0];
      end
      trk12_ff <= trk11_ff;
      ssum_ff <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);

      trk_d_ff[0] <= trk12_ff;
      for (int k = 1; k < NS; k++) begin
         trk_d_ff[k] <= trk_d_ff[k-1];
      end
   end

   vpnt_isqrt u_isqrt (
      .clock    (clock),
      .radicand (ssum_ff),
      .root     (root)
   );

   always_comb begin
      logic [NUM_W-1:0] num2;
      div_den_in = trk_d_ff[NS-1].op ? DW'(root) : trk_d_ff[NS-1].den;
      ds_in.op = trk_d_ff[NS-1].op;
      ds_in.code = trk_d_ff[NS-1].code;
      ds_in.neg = trk_d_ff[NS-1].neg;
      for (int i = 0; i < 3; i++) begin
         num2 = NUM_W'(trk_d_ff[NS-1].val[i]) << (FRAC_BITS + 1);
         dhi_in[i] = DW'(num2 >> QW);
         dlo_in[i] = num2[QW-1:0];
         ds_in.presat[i] = (PS_W'(num2) >= {div_den_in, QW'(0)});
      end
   end

   always_ff @(posedge clock) begin
      dhi_ff <= dhi_in;
      dlo_ff <= dlo_in;
      dden_ff <= div_den_in;
      ds_ff <= ds_in;
      ds_d_ff[0] <= ds_ff;
      for (int k = 1; k < QW; k++) begin
         ds_d_ff[k] <= ds_d_ff[k-1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vpnt_div u_div (
         .clock       (clock),
         .dividend_hi (dhi_ff[i]),
         .dividend_lo (dlo_ff[i]),
         .divisor     (dden_ff),
         .quotient    (quo[i])
      );
   end

   always_comb begin
      logic [QW:0]   qinc;
      logic [QW-1:0] q;
      logic [QW-1:0] lim;
      logic          sat;
      logic          any_sat;
      any_sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         qinc = {1'b0, quo[i]} + 1'b1;
         q = qinc[QW:1];
         lim = ds_d_ff[QW-1].neg[i] ? QW'(32'h8000_0000) : QW'(32'h7FFF_FFFF);
         sat = ds_d_ff[QW-1].presat[i] || (q > lim);
         if (sat) begin
            q = lim;
            any_sat = 1'b1;
         end
         res_in[i] = ds_d_ff[QW-1].neg[i] ? -$signed(q[31:0]) : $signed(q[31:0]);
      end
      if (ds_d_ff[QW-1].code != vpnt_pkg::ST_OK) begin
         st_in = ds_d_ff[QW-1].code;
         for (int i = 0; i < 3; i++) begin
            res_in[i] = '0;
         end
      end else if (any_sat && !ds_d_ff[QW-1].op) begin
         st_in = vpnt_pkg::ST_SAT;
      end else begin
         st_in = vpnt_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      st_ff <= st_in;
      kind_ff <= ds_d_ff[QW-1].op;
   end

   assign rsp_valid = vld_ff[PD-1];
   assign rsp_kind = kind_ff;
   assign rsp_out_x = res_ff[0];
   assign rsp_out_y = res_ff[1];
   assign rsp_out_z = res_ff[2];
   assign rsp_status = st_ff;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench of the vertex position and normal transform pipeline.
`timescale 1ns / 100ps

module testbench;

   localparam int FB = 16;
   localparam int STALL_LIMIT = 3000;

   typedef struct {
      logic               op;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vertex_type;

   typedef struct {
      logic                 kind;
      logic signed [31:0]   x;
      logic signed [31:0]   y;
      logic signed [31:0]   z;
      vpnt_pkg::status_type code;
   } xform_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_op = 1'b0;
   logic signed [31:0] req_in_x = '0;
   logic signed [31:0] req_in_y = '0;
   logic signed [31:0] req_in_z = '0;
   logic               rsp_valid;
   logic               rsp_kind;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic [1:0]         rsp_status;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   vertex_type  vertex_q[$];
   xform_type   xform_q[$];
   vertex_type  next_vertex;
   logic [63:0] matrix_regs[vpnt_pkg::N_REGS];
   int          matrix[4][4];
   int          sender_idle_pct = 0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;

   vertex_position_normal_transform uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_in_x(req_in_x), .req_in_y(req_in_y), .req_in_z(req_in_z),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [127:0] entry(int r, int c);
      logic [63:0]        w;
      logic signed [31:0] e;
      logic signed [127:0] wide;
      w = matrix_regs[r * 2 + c / 2];
      e = (c % 2) ? w[63:32] : w[31:0];
      wide = e;
      return wide;
   endfunction

   function automatic int bit_length(logic [127:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) begin
         if (v[i]) n = i + 1;
      end
      return n;
   endfunction

   function automatic xform_type transform_vertex(vertex_type v);
      xform_type           res;
      logic signed [127:0] vv[3];
      logic signed [127:0] acc[4];
      logic signed [127:0] cof[3][3];
      logic signed [127:0] det;
      logic signed [127:0] u[3];
      logic signed [127:0] p;
      logic signed [127:0] s;
      logic [127:0]        den;
      logic [127:0]        num;
      logic [127:0]        q;
      logic [127:0]        rem;
      logic [127:0]        lim;
      logic [127:0]        mag[3];
      logic [63:0]         m[3];
      logic [63:0]         sum;
      logic [63:0]         len;
      logic [63:0]         t;
      logic [63:0]         nq;
      logic [63:0]         nr;
      logic [31:0]         o[3];
      logic                neg;
      int                  b;
      int                  r0;
      int                  r1;
      int                  c0;
      int                  c1;
      res.kind = v.op;
      res.code = vpnt_pkg::ST_OK;
      o[0] = '0;
      o[1] = '0;
      o[2] = '0;
      vv[0] = v.x;
      vv[1] = v.y;
      vv[2] = v.z;
      if (v.op == 1'b0) begin
         for (int r = 0; r < 4; r++) begin
            acc[r] = entry(r, 3) <<< FB;
            for (int c = 0; c < 3; c++) acc[r] = acc[r] + entry(r, c) * vv[c];
         end
         if (acc[3] == 0) begin
            res.code = vpnt_pkg::ST_WZERO;
         end else begin
            den = (acc[3] < 0) ? -acc[3] : acc[3];
            for (int r = 0; r < 3; r++) begin
               neg = acc[r][127] != acc[3][127];
               num = ((acc[r] < 0) ? -acc[r] : acc[r]);
               num = num << FB;
               q = num / den;
               rem = num % den;
               if ((rem << 1) >= den) q = q + 1;
               lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
               if (q > lim) begin
                  q = lim;
                  res.code = vpnt_pkg::ST_SAT;
               end
               o[r] = neg ? -q[31:0] : q[31:0];
            end
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            r0 = (i == 0) ? 1 : 0;
            r1 = (i == 2) ? 1 : 2;
            for (int j = 0; j < 3; j++) begin
               c0 = (j == 0) ? 1 : 0;
               c1 = (j == 2) ? 1 : 2;
               p = entry(r0, c0) * entry(r1, c1);
               s = entry(r0, c1) * entry(r1, c0);
               cof[i][j] = ((i + j) % 2) ? s - p : p - s;
            end
         end
         det = 0;
         for (int j = 0; j < 3; j++) det = det + entry(0, j) * cof[0][j];
         if (det == 0) begin
            res.code = vpnt_pkg::ST_DEGEN;
         end else begin
            b = 0;
            for (int i = 0; i < 3; i++) begin
               u[i] = 0;
               for (int j = 0; j < 3; j++) u[i] = u[i] + cof[i][j] * vv[j];
               if (det < 0) u[i] = -u[i];
               mag[i] = (u[i] < 0) ? -u[i] : u[i];
               if (bit_length(mag[i]) > b) b = bit_length(mag[i]);
            end
            if (b == 0) begin
               res.code = vpnt_pkg::ST_DEGEN;
            end else begin
               sum = 0;
               for (int i = 0; i < 3; i++) begin
                  num = (b > 30) ? (mag[i] >> (b - 30)) : (mag[i] << (30 - b));
                  m[i] = num[63:0];
                  sum = sum + m[i] * m[i];
               end
               len = 0;
               for (int k = 31; k >= 0; k--) begin
                  t = len | (64'd1 << k);
                  if (t * t <= sum) len = t;
               end
               for (int i = 0; i < 3; i++) begin
                  nq = (m[i] << FB) / len;
                  nr = (m[i] << FB) % len;
                  if (nr * 2 >= len) nq = nq + 1;
                  o[i] = (u[i] < 0) ? -nq[31:0] : nq[31:0];
               end
            end
         end
      end
      res.x = o[0];
      res.y = o[1];
      res.z = o[2];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Driver: the held transaction is taken when start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) xform_q.push_back(transform_vertex('{req_op, req_in_x,
                                                                 req_in_y, req_in_z}));
         if (!start || !busy) begin
            if (vertex_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_vertex = vertex_q.pop_front();
               start <= 1'b1;
               req_op <= next_vertex.op;
               req_in_x <= next_vertex.x;
               req_in_y <= next_vertex.y;
               req_in_z <= next_vertex.z;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      xform_type want;
      if (!reset && rsp_valid) begin
         if (xform_q.size() == 0) begin
            $display("%0t: result with no transaction outstanding", $time);
            mismatch_count++;
         end else begin
            want = xform_q.pop_front();
            if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
            if (rsp_status !== want.code) report_mismatch("status", rsp_status, want.code);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("vertex_position_normal_transform regression: fail");
            $finish;
         end
      end
   end

   function automatic int rand_field(int mode);
      case (mode)
         0: return $urandom;
         1: return int'($urandom_range(0, 33554432)) - 16777216;
         default: return int'($urandom_range(0, 1048576)) - 524288;
      endcase
   endfunction

   task automatic add_vertex(logic op, int x, int y, int z);
      vertex_q.push_back('{op, x, y, z});
   endtask

   task automatic add_random(int count);
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 3);
         add_vertex($urandom_range(0, 1), rand_field(mode), rand_field(mode),
                    rand_field(mode));
      end
   endtask

   task automatic drain();
      while (vertex_q.size() > 0 || start || xform_q.size() > 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic load_matrix();
      vpnt_pkg::reg_idx_type idx;
      for (int r = 0; r < 4; r++) begin
         for (int h = 0; h < 2; h++) begin
            idx = vpnt_pkg::reg_idx_type'(r * 2 + h);
            @(posedge clock);
            csr_wr_en <= 1'b1;
            csr_index <= idx;
            csr_wdata <= {matrix[r][2 * h + 1], matrix[r][2 * h]};
            matrix_regs[idx] = {matrix[r][2 * h + 1], matrix[r][2 * h]};
         end
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      repeat (6) @(posedge clock);
   endtask

   task automatic random_matrix(bit full);
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            matrix[r][c] = full ? int'($urandom) : int'($urandom_range(0, 524288)) - 262144;
         end
      end
   endtask

   initial begin
      matrix_regs[vpnt_pkg::REG_R0_C01] = 64'd1 << FB;
      matrix_regs[vpnt_pkg::REG_R0_C23] = '0;
      matrix_regs[vpnt_pkg::REG_R1_C01] = 64'd1 << (FB + 32);
      matrix_regs[vpnt_pkg::REG_R1_C23] = '0;
      matrix_regs[vpnt_pkg::REG_R2_C01] = '0;
      matrix_regs[vpnt_pkg::REG_R2_C23] = 64'd1 << FB;
      matrix_regs[vpnt_pkg::REG_R3_C01] = '0;
      matrix_regs[vpnt_pkg::REG_R3_C23] = 64'd1 << (FB + 32);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_vertex(1'b0, 0, 0, 0);
      add_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_vertex(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vertex(1'b0, -1, 1, 65536);
      add_vertex(1'b1, 0, 0, 0);
      add_vertex(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1);
      add_vertex(1'b1, -1, 0, 0);
      add_vertex(1'b1, 3, -4, 5);
      add_random(60);
      drain();

      matrix = '{'{65536, 0, 0, 0}, '{0, 65536, 0, 0}, '{65536, 0, 0, 0}, '{0, 0, 0, 0}};
      load_matrix();
      add_vertex(1'b0, 65536, 2, 3);
      add_vertex(1'b0, 0, 0, 0);
      add_vertex(1'b1, 65536, 65536, 65536);
      sender_idle_pct = 83;
      add_random(70);
      drain();

      matrix = '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                 '{32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000},
                 '{-1, 0, 32'h7FFF_FFFF, 0}, '{0, 0, 0, -65536}};
      load_matrix();
      add_vertex(1'b0, 32'h7FFF_FFFF, 0, 0);
      add_vertex(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      add_vertex(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      sender_idle_pct = 0;
      add_random(70);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         random_matrix(ph == 2);
         load_matrix();
         sender_idle_pct = (ph == 1) ? 38 : (ph == 3) ? 83 : 0;
         add_random(60);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("vertex_position_normal_transform regression: pass");
      end else begin
         $display("vertex_position_normal_transform regression: fail");
      end
      $finish;
   end

endmodule
